/* sv/vpt_pkg.sv */
// Package: payload types, controller/datapath command types and constants.
package vpt_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  localparam logic [1:0] SEL_MODEL = 2'd0;
  localparam logic [1:0] SEL_VIEWPROJ = 2'd1;
  localparam logic [1:0] SEL_VIEWPORT = 2'd2;

  typedef struct packed {
    logic op;
    logic [1:0] matrix_sel;
    logic [3:0] entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_s;
    logic signed [31:0] tex_t;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] screen_z;
    logic signed [31:0] out_s;
    logic signed [31:0] out_t;
    logic w_zero;
  } out_item_t;

  // Dot-product phase selects operand sources.
  localparam logic [1:0] PH_COMB = 2'd0;
  localparam logic [1:0] PH_HOM = 2'd1;
  localparam logic [1:0] PH_NRM = 2'd2;
  localparam logic [1:0] PH_SCR = 2'd3;

  typedef struct packed {
    logic load;       // capture input item
    logic mat_wr;     // write matrix entry
    logic mac_clr;    // clear accumulator
    logic mac_en;     // accumulate one product
    logic [1:0] phase;
    logic [3:0] row;  // result index
    logic [1:0] k;    // term index
    logic store;      // store saturated result
    logic div_start;
    logic finish;     // capture result into output register
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic w_zero;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7fffffff;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

/* sv/vpt_ctrl.sv */
// Controller: sequences matrix product, transform, reciprocal, scale and viewport.
module vpt_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_op,
  input  logic out_busy,
  input  vpt_pkg::sts_t sts,
  output logic in_stall,
  output vpt_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DOT  = 3'd1;
  localparam logic [2:0] S_DIVS = 3'd2;
  localparam logic [2:0] S_DIVW = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state, state_next;
  logic [1:0] phase, phase_next;
  logic [3:0] row, row_next;
  logic [2:0] k, k_next;

  logic [3:0] last_row;
  assign last_row = (phase == vpt_pkg::PH_COMB) ? 4'd15 : 4'd3;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    phase_next = phase;
    row_next = row;
    k_next = k;
    cmd = '0;
    cmd.phase = phase;
    cmd.row = row;
    cmd.k = k[1:0];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_op == vpt_pkg::OP_LOAD) begin
            cmd.mat_wr = 1'b1;
          end else begin
            state_next = S_DOT;
            phase_next = vpt_pkg::PH_COMB;
            row_next = 4'd0;
            k_next = 3'd0;
            cmd.mac_clr = 1'b1;
          end
        end
      end
      S_DOT: begin
        if (k == 3'd4 || (phase == vpt_pkg::PH_NRM && k == 3'd1)) begin
          cmd.store = 1'b1;
          cmd.mac_clr = 1'b1;
          k_next = 3'd0;
          if (row == last_row) begin
            row_next = 4'd0;
            case (phase)
              vpt_pkg::PH_COMB: phase_next = vpt_pkg::PH_HOM;
              vpt_pkg::PH_HOM: state_next = S_DIVS;
              vpt_pkg::PH_NRM: phase_next = vpt_pkg::PH_SCR;
              default: state_next = S_DONE;
            endcase
          end else begin
            row_next = row + 4'd1;
          end
        end else begin
          cmd.mac_en = 1'b1;
          k_next = k + 3'd1;
        end
      end
      S_DIVS: begin
        if (sts.w_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_next = S_DIVW;
        end
      end
      S_DIVW: begin
        if (!sts.div_busy) begin
          state_next = S_DOT;
          phase_next = vpt_pkg::PH_NRM;
          row_next = 4'd0;
          k_next = 3'd0;
          cmd.mac_clr = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= vpt_pkg::PH_COMB;
      row <= 4'd0;
      k <= 3'd0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      row <= row_next;
      k <= k_next;
    end
  end

endmodule

/* sv/vpt_recip.sv */
// Reciprocal unit: restoring divide of 2^(2*FRAC_BITS) by |w|, one bit a cycle.
module vpt_recip #(
  parameter int FRAC_BITS = vpt_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [31:0] w,
  output logic busy,
  output logic signed [31:0] recip
);

  localparam int NB = 2 * FRAC_BITS + 1;
  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0] quo;
  logic [32:0] rem;
  logic [31:0] mag;
  logic neg;
  logic [CW-1:0] cnt;
  logic [33:0] trial;

  assign trial = {rem, (cnt == CW'(NB)) ? 1'b1 : 1'b0} - {2'b00, mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CW'(NB);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= w[31];
      mag <= w[31] ? 32'(-w) : w;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      if (!trial[33]) begin
        rem <= trial[32:0];
        quo <= {quo[NB-2:0], 1'b1};
      end else begin
        rem <= {rem[31:0], (cnt == CW'(NB)) ? 1'b1 : 1'b0};
        quo <= {quo[NB-2:0], 1'b0};
      end
    end
  end

  logic [63:0] q64;
  assign q64 = 64'(quo);

  always_comb begin
    if (neg) recip = (q64 > 64'd2147483648) ? 32'sh80000000 : 32'(-q64);
    else recip = (q64 > 64'd2147483647) ? 32'sh7fffffff : q64[31:0];
  end

endmodule

/* sv/vpt_datapath.sv */
// Datapath: matrices, shared multiply-accumulate, vector registers, output register.
module vpt_datapath #(
  parameter int FRAC_BITS = vpt_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  vpt_pkg::in_item_t in_item,
  input  vpt_pkg::cmd_t cmd,
  input  logic out_stall,
  output vpt_pkg::sts_t sts,
  output logic out_busy,
  output logic out_valid,
  output vpt_pkg::out_item_t out_item
);

  logic signed [31:0] mm [16];
  logic signed [31:0] vp [16];
  logic signed [31:0] pm [16];
  logic signed [31:0] comb [16];
  logic signed [31:0] hom [4];
  logic signed [31:0] nrm [4];
  logic signed [31:0] scr [3];
  logic signed [31:0] vx, vy, vz, ts, tt;
  logic signed [31:0] a, b, recip;
  logic signed [63:0] prod, acc;
  logic signed [63:0] prod_sh;
  logic div_busy;
  logic wz;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mm[i] <= '0;
        vp[i] <= '0;
        pm[i] <= '0;
      end
    end else if (cmd.mat_wr) begin
      case (in_item.matrix_sel)
        vpt_pkg::SEL_MODEL: mm[in_item.entry_index] <= in_item.entry_value;
        vpt_pkg::SEL_VIEWPROJ: vp[in_item.entry_index] <= in_item.entry_value;
        vpt_pkg::SEL_VIEWPORT: pm[in_item.entry_index] <= in_item.entry_value;
        default: ;
      endcase
    end
  end

  logic signed [31:0] vtx_k;
  always_comb begin
    case (cmd.k)
      2'd0: vtx_k = vx;
      2'd1: vtx_k = vy;
      2'd2: vtx_k = vz;
      default: vtx_k = 32'sd1 <<< FRAC_BITS;
    endcase
  end

  always_comb begin
    case (cmd.phase)
      vpt_pkg::PH_COMB: begin
        a = vp[{cmd.row[3:2], cmd.k}];
        b = mm[{cmd.k, cmd.row[1:0]}];
      end
      vpt_pkg::PH_HOM: begin
        a = comb[{cmd.row[1:0], cmd.k}];
        b = vtx_k;
      end
      vpt_pkg::PH_NRM: begin
        a = hom[cmd.row[1:0]];
        b = recip;
      end
      default: begin
        a = pm[{cmd.row[1:0], cmd.k}];
        b = nrm[cmd.k];
      end
    endcase
  end

  assign prod = 64'(a) * 64'(b);
  assign prod_sh = prod >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (cmd.mac_clr) acc <= '0;
    else if (cmd.mac_en) acc <= acc + prod_sh;
  end

  logic signed [31:0] res;
  assign res = vpt_pkg::sat32(acc);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx <= in_item.pos_x;
      vy <= in_item.pos_y;
      vz <= in_item.pos_z;
      ts <= in_item.tex_s;
      tt <= in_item.tex_t;
    end
    if (cmd.store) begin
      case (cmd.phase)
        vpt_pkg::PH_COMB: comb[cmd.row] <= res;
        vpt_pkg::PH_HOM: hom[cmd.row[1:0]] <= res;
        vpt_pkg::PH_NRM: nrm[cmd.row[1:0]] <= res;
        default: if (cmd.row[1:0] != 2'd3) scr[cmd.row[1:0]] <= res;
      endcase
    end
  end

  assign wz = (hom[3] == 32'sd0);

  vpt_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
    .clk(clk),
    .rst(rst),
    .start(cmd.div_start),
    .w(hom[3]),
    .busy(div_busy),
    .recip(recip)
  );

  assign sts.div_busy = div_busy;
  assign sts.w_zero = wz;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item.screen_x <= wz ? 32'sd0 : scr[0];
      out_item.screen_y <= wz ? 32'sd0 : scr[1];
      out_item.screen_z <= wz ? 32'sd0 : scr[2];
      out_item.out_s <= ts;
      out_item.out_t <= tt;
      out_item.w_zero <= wz;
    end
  end

  assign out_busy = out_valid && out_stall;

endmodule

/* sv/vertex_projection_transform.sv */
// Top level: vertex transform with perspective divide and viewport mapping.
// Input channel in_valid/in_stall carries in_item. op LOAD writes one entry of
// the modeling, viewing-projection or viewport matrix and gives no result; a
// selector of 3 is ignored. op XFORM transforms one vertex. A transform runs
// on one shared 32x32 multiplier under the controller: 16 entries of C = V*M,
// 4 rows of h, a reciprocal of w, 4 scalings and 4 viewport rows, in that
// order. The next item can be taken as soon as the result is in the output
// register. With w zero the reciprocal, scale and viewport steps are skipped
// and positions read 0 with w_zero set.
// Output channel out_valid/out_stall carries out_item from a register; a
// stall holds it, and the block waits to finish the next result until the
// register is free. Reset clears all three matrices and the control state.
module vertex_projection_transform #(
  parameter int FRAC_BITS = vpt_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  vpt_pkg::in_item_t in_item,
  output logic out_valid,
  input  logic out_stall,
  output vpt_pkg::out_item_t out_item
);

  vpt_pkg::cmd_t cmd;
  vpt_pkg::sts_t sts;
  logic out_busy;

  vpt_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_op(in_item.op),
    .out_busy(out_busy),
    .sts(sts),
    .in_stall(in_stall),
    .cmd(cmd)
  );

  vpt_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk),
    .rst(rst),
    .in_item(in_item),
    .cmd(cmd),
    .out_stall(out_stall),
    .sts(sts),
    .out_busy(out_busy),
    .out_valid(out_valid),
    .out_item(out_item)
  );

endmodule
